FILE: hw/rtl/vru_pkg.sv
// Shared types and a saturation helper for the vector refraction pipeline.
package vru_pkg;

   localparam int INNER_WIDTH = 32;
   localparam int WIDE_WIDTH  = 66;

   typedef logic signed [INNER_WIDTH-1:0] inner_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;

   localparam wide_type INNER_MAX = wide_type'(64'sd2147483647);
   localparam wide_type INNER_MIN = -wide_type'(64'sd2147483648);

   function automatic inner_type sat_inner(input wide_type v);
      inner_type r;
      if (v > INNER_MAX) begin
         r = inner_type'(INNER_MAX);
      end else if (v < INNER_MIN) begin
         r = inner_type'(INNER_MIN);
      end else begin
         r = inner_type'(v);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/vru_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module vru_sqrt #(
   parameter int XW = 45,
   parameter int SW = 144
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [XW-1:0]           in_x,
   input  logic [SW-1:0]           in_side,
   output logic                    out_valid,
   output logic [(XW+1)/2-1:0]     out_root,
   output logic [SW-1:0]           out_side
);
   localparam int RW = (XW + 1) / 2;
   localparam int PX = 2 * RW;
   localparam int RB = RW + 2;

   logic          v_ff    [RW];
   logic [RB-1:0] rem_ff  [RW];
   logic [RW-1:0] q_ff    [RW];
   logic [PX-1:0] x_ff    [RW];
   logic [SW-1:0] side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic          v_prev;
      logic [RB-1:0] rem_prev;
      logic [RW-1:0] q_prev;
      logic [PX-1:0] x_prev;
      logic [SW-1:0] side_prev;
      logic [RB-1:0] rem_sh;
      logic [RB-1:0] trial;
      logic [RB-1:0] rem_in;
      logic [RW-1:0] q_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign q_prev    = '0;
         assign x_prev    = PX'(in_x);
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[RW-1:0], x_prev[PX-1:PX-2]};
         trial  = {q_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            q_in   = {q_prev[RW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            x_ff[k]    <= {x_prev[PX-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = q_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

FILE: hw/rtl/vector_refract_unit_top.sv
// Top level of the vector refraction pipeline.
// Refracts one ray per clock unless the output stalls: R = ratio*(D + c*N) -
// sqrt(|1 - |P|^2|)*N with c = min(1, -D.N), fixed point with FRACTION_BITS
// fraction bits. The pipe has 10 stages plus one stage per square-root result
// bit ((31+FRACTION_BITS+1)/2, 23 at defaults). A word is taken every cycle,
// but the whole pipeline holds while a finished word waits on rsp_tready.
module vector_refract_unit_top #(
   parameter int FRACTION_BITS   = 14,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, index_ratio
   input  logic [((7*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x, out_y, out_z
   output logic [((3*(COMPONENT_WIDTH+2)+7)/8)*8-1:0] rsp_tdata
);
   import vru_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int FB = FRACTION_BITS;
   localparam int OW = CW + 2;
   localparam int XW = INNER_WIDTH - 1 + FB;
   localparam int RW = (XW + 1) / 2;
   localparam int SW = 3 * INNER_WIDTH + 3 * CW;
   localparam int OD = ((3 * OW + 7) / 8) * 8;

   localparam inner_type ONE = inner_type'(64'sd1 <<< FB);
   localparam wide_type  OUT_MAX = (wide_type'(1) <<< (OW - 1)) - wide_type'(1);
   localparam wide_type  OUT_MIN = -(wide_type'(1) <<< (OW - 1));

   logic en;

   logic                 v1_ff;
   logic signed [CW-1:0] d1_ff [3];
   logic signed [CW-1:0] n1_ff [3];
   logic        [CW-1:0] r1_ff;

   logic                 v2_ff;
   wide_type             pd2_ff [3];
   logic signed [CW-1:0] d2_ff [3];
   logic signed [CW-1:0] n2_ff [3];
   logic        [CW-1:0] r2_ff;

   logic                 v3_ff;
   inner_type            c3_ff;
   inner_type            c3_in;
   logic signed [CW-1:0] d3_ff [3];
   logic signed [CW-1:0] n3_ff [3];
   logic        [CW-1:0] r3_ff;

   logic                 v4_ff;
   wide_type             cn4_ff [3];
   logic signed [CW-1:0] d4_ff [3];
   logic signed [CW-1:0] n4_ff [3];
   logic        [CW-1:0] r4_ff;

   logic                 v5_ff;
   inner_type            t5_ff [3];
   logic signed [CW-1:0] n5_ff [3];
   logic        [CW-1:0] r5_ff;

   logic                 v6_ff;
   inner_type            p6_ff [3];
   logic signed [CW-1:0] n6_ff [3];

   logic                 v7_ff;
   wide_type             sq7_ff [3];
   inner_type            p7_ff [3];
   logic signed [CW-1:0] n7_ff [3];

   logic                 v8_ff;
   logic [INNER_WIDTH-2:0] m8_ff;
   logic [INNER_WIDTH-2:0] m8_in;
   inner_type            p8_ff [3];
   logic signed [CW-1:0] n8_ff [3];

   logic                 vq;
   logic [RW-1:0]        root_q;
   logic [SW-1:0]        side_in;
   logic [SW-1:0]        side_q;
   inner_type            p9 [3];
   logic signed [CW-1:0] n9 [3];

   logic                 v10_ff;
   inner_type            par10_ff [3];
   inner_type            p10_ff [3];

   logic                 vo_ff;
   logic signed [OW-1:0] o_ff [3];
   logic signed [OW-1:0] o_in [3];

   assign en         = !vo_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      wide_type s;
      wide_type diff;
      inner_type sq;
      s = pd2_ff[0] + pd2_ff[1] + pd2_ff[2];
      c3_in = sat_inner(s);
      if (c3_in > ONE) begin
         c3_in = ONE;
      end
      sq = sat_inner(sq7_ff[0] + sq7_ff[1] + sq7_ff[2]);
      diff = wide_type'(ONE) - wide_type'(sq);
      if (diff < 0) begin
         diff = -diff;
      end
      if (diff > INNER_MAX) begin
         diff = INNER_MAX;
      end
      m8_in = diff[INNER_WIDTH-2:0];
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign side_in[i*INNER_WIDTH +: INNER_WIDTH] = p8_ff[i];
      assign side_in[3*INNER_WIDTH + i*CW +: CW]  = n8_ff[i];
      assign p9[i] = side_q[i*INNER_WIDTH +: INNER_WIDTH];
      assign n9[i] = side_q[3*INNER_WIDTH + i*CW +: CW];

      always_comb begin
         wide_type s;
         s = wide_type'(p10_ff[i]) + wide_type'(par10_ff[i]);
         if (s > OUT_MAX) begin
            o_in[i] = OW'(OUT_MAX);
         end else if (s < OUT_MIN) begin
            o_in[i] = OW'(OUT_MIN);
         end else begin
            o_in[i] = OW'(s);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d1_ff[i]  <= req_tdata[i*CW +: CW];
            n1_ff[i]  <= req_tdata[(3+i)*CW +: CW];
            pd2_ff[i] <= (-(wide_type'(d1_ff[i])) * wide_type'(n1_ff[i])) >>> FB;
            d2_ff[i]  <= d1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            d3_ff[i]  <= d2_ff[i];
            n3_ff[i]  <= n2_ff[i];
            cn4_ff[i] <= (wide_type'(c3_ff) * wide_type'(n3_ff[i])) >>> FB;
            d4_ff[i]  <= d3_ff[i];
            n4_ff[i]  <= n3_ff[i];
            t5_ff[i]  <= sat_inner(wide_type'(d4_ff[i]) + wide_type'(sat_inner(cn4_ff[i])));
            n5_ff[i]  <= n4_ff[i];
            p6_ff[i]  <= sat_inner((wide_type'({1'b0, r5_ff}) * wide_type'(t5_ff[i])) >>> FB);
            n6_ff[i]  <= n5_ff[i];
            sq7_ff[i] <= (wide_type'(p6_ff[i]) * wide_type'(p6_ff[i])) >>> FB;
            p7_ff[i]  <= p6_ff[i];
            n7_ff[i]  <= n6_ff[i];
            p8_ff[i]  <= p7_ff[i];
            n8_ff[i]  <= n7_ff[i];
            par10_ff[i] <= sat_inner(-((wide_type'({1'b0, root_q}) * wide_type'(n9[i])) >>> FB));
            p10_ff[i] <= p9[i];
            o_ff[i]   <= o_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= req_tdata[6*CW +: CW];
         r2_ff <= r1_ff;
         r3_ff <= r2_ff;
         r4_ff <= r3_ff;
         r5_ff <= r4_ff;
         c3_ff <= c3_in;
         m8_ff <= m8_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v10_ff <= 1'b0;
         vo_ff  <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_tvalid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v10_ff <= vq;
         vo_ff  <= v10_ff;
      end
   end

   vru_sqrt #(
      .XW (XW),
      .SW (SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_x      ({m8_ff, FB'(0)}),
      .in_side   (side_in),
      .out_valid (vq),
      .out_root  (root_q),
      .out_side  (side_q)
   );

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = OD'({o_ff[2], o_ff[1], o_ff[0]});

endmodule

FILE: hw/rtl/vru_checker.sv
// Port-level checks for the vector refraction pipeline, bound to the top level.
module vru_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [53:0] rsp_tdata
);
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");
endmodule

bind vector_refract_unit_top vru_checker u_vru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata[53:0])
);

FILE: sim/vru_refraction_checker.sv
// Refraction predictor and response checker for the vector refraction unit.
module vru_refraction_checker #(
   parameter int FRACTION_BITS   = 14,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [(((7*COMPONENT_WIDTH+7)/8)*8)-1:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [(((3*(COMPONENT_WIDTH+2)+7)/8)*8)-1:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          rays_checked
);
   import vru_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int OW = COMPONENT_WIDTH + 2;

   typedef logic [3*OW-1:0] ray_out_type;

   ray_out_type expected_rays[$];

   function automatic wide_type mul_fix(input wide_type a, input wide_type b);
      wide_type p;
      p = a * b;
      return p >>> FRACTION_BITS;
   endfunction

   function automatic logic [63:0] isqrt(input logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [OW-1:0] sat_out(input wide_type v);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (OW-1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OW-1:0];
   endfunction

   function automatic ray_out_type refract_ray(input logic [7*CW-1:0] w);
      wide_type d[3], n[3], perp[3];
      wide_type one, ratio, cosv, sq, m, root, t, par;
      logic [63:0] rt;
      ray_out_type r;
      one = wide_type'(1) <<< FRACTION_BITS;
      for (int i = 0; i < 3; i++) begin
         d[i] = wide_type'($signed(w[i*CW +: CW]));
         n[i] = wide_type'($signed(w[(3+i)*CW +: CW]));
      end
      ratio = wide_type'({1'b0, w[6*CW +: CW]});
      cosv = sat_inner(mul_fix(-d[0], n[0]) + mul_fix(-d[1], n[1]) + mul_fix(-d[2], n[2]));
      if (cosv > one) cosv = one;
      for (int i = 0; i < 3; i++) begin
         t = sat_inner(d[i] + sat_inner(mul_fix(cosv, n[i])));
         perp[i] = sat_inner(mul_fix(ratio, t));
      end
      sq = sat_inner(mul_fix(perp[0], perp[0]) + mul_fix(perp[1], perp[1])
                     + mul_fix(perp[2], perp[2]));
      m = one - sq;
      if (m < 0) m = -m;
      m = sat_inner(m);
      rt = isqrt(64'(m) << FRACTION_BITS);
      root = wide_type'(rt);
      for (int i = 0; i < 3; i++) begin
         par = sat_inner(-mul_fix(root, n[i]));
         r[i*OW +: OW] = sat_out(perp[i] + par);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rays_checked = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      ray_out_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rays.push_back(refract_ray(req_tdata[7*CW-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rays.size() == 0) begin
               report_mismatch("response word with no ray pending");
            end else begin
               want = expected_rays.pop_front();
               rays_checked++;
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[i*OW +: OW] !== want[i*OW +: OW])
                     report_mismatch($sformatf("component %0d got %h want %h", i,
                        rsp_tdata[i*OW +: OW], want[i*OW +: OW]));
            end
         end
      end
      pending_count = expected_rays.size();
   end
endmodule

FILE: sim/tb_vector_refract_unit_top.sv
// Stimulus and verdict for the vector refraction unit.
module tb_vector_refract_unit_top;
   localparam int CW = 16;
   localparam int REQ_W = ((7*CW+7)/8)*8;
   localparam int RSP_W = ((3*(CW+2)+7)/8)*8;
   localparam logic [15:0] ONE = 16'sd16384;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [RSP_W-1:0] rsp_tdata;
   int fail_count, pending_count, rays_checked;
   int sent;
   bit idle_en, hold_rsp;

   vector_refract_unit_top uut (.*);

   vru_refraction_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tb_vector_refract_unit_top NOT OK");
      $finish;
   end

   function automatic logic [15:0] rnd_comp(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 32768) - 16384);
         default: return 16'($urandom_range(0, 4) * 8192 - 16384);
      endcase
   endfunction

   task automatic send_ray(input logic [15:0] dx, dy, dz, nx, ny, nz, ratio);
      req_tdata <= {{(REQ_W-7*CW){1'b0}}, ratio, nz, ny, nx, dz, dy, dx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (idle_en && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_random(input int count);
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 2);
         send_ray(rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
                  rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(8192, 24576)));
      end
   endtask

   // Response side: random stalls, plus one long hold-off while words pile up.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_rsp)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !idle_en || ($urandom_range(0, 99) >= 35);
   end

   initial begin
      hold_rsp = 0;
      wait (sent >= 60);
      @(posedge clock);
      hold_rsp = 1;
      repeat (150) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      sent = 0;
      idle_en = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: extremes, axis-aligned, grazing, reversed and zero cases
      send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
      send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_ray(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
      send_ray(0, 0, -ONE, 0, 0, ONE, ONE);
      send_ray(0, 0, -ONE, 0, 0, ONE, 16'd10923);
      send_ray(0, 0, ONE, 0, 0, ONE, ONE);
      send_ray(ONE, 0, 0, 0, 0, ONE, 16'd24576);
      send_ray(16'd11585, 0, -16'sd11585, 0, 0, ONE, 16'd24576);
      send_ray(16'd11585, 0, -16'sd11585, 0, 0, ONE, 16'hFFFF);
      send_ray(0, 0, 0, 0, 0, 0, 0);
      send_ray(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_ray(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_ray(-ONE, 0, 0, ONE, 0, 0, 16'd8192);
      send_ray(16'd8000, 16'd9000, -16'sd10000, 0, ONE, 0, 16'd20000);
      send_random(120);
      // pause until the pipe drains
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(posedge clock);
      idle_en = 0;
      send_random(100);
      idle_en = 1;
      send_random(170);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d rays (directed extremes plus random unit and raw vectors);", sent);
      $display("checked %0d responses with stalls on both sides.", rays_checked);
      if (fail_count == 0)
         $display("tb_vector_refract_unit_top OK");
      else
         $display("tb_vector_refract_unit_top NOT OK");
      $finish;
   end
endmodule
